// ===== hdl/fovc_pkg.sv =====
// shared constants, widths and the arctangent table for the fov axis conversion core
// no dependencies; imported by every module under hdl

package fovc_pkg;

    localparam int ANGLE_BITS_DEF    = 16;
    localparam int CORDIC_STAGES_DEF = 16;

    // q30 angle accumulator and rotation coordinates, signed
    localparam int ZW = 33;
    localparam int RW = 33;
    // aspect ratio, unsigned q8.8
    localparam int RATIO_W = 16;
    localparam int RATIO_FRAC = 8;
    localparam logic [RATIO_W-1:0] RATIO_RESET = 16'd256;
    // clamped rotation coordinate, product and vectoring coordinate widths
    localparam int CLAMP_W = RW - 1;
    localparam int PROD_W = CLAMP_W + RATIO_W;
    localparam int VW = PROD_W - RATIO_FRAC + 3;

    localparam int FRAC_Q30 = 30;
    localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

    typedef enum logic
    {
        OP_FROM_HORIZONTAL = 1'b0,
        OP_FROM_VERTICAL   = 1'b1
    } fovc_op_t;

    // atan(2^-i) in q30, truncated
    function automatic logic [31:0] fovc_atan(input int idx);
        logic [31:0] val;
        case (idx)
            0:  val = 32'h3243F6A8;
            1:  val = 32'h1DAC6705;
            2:  val = 32'h0FADBAFC;
            3:  val = 32'h07F56EA6;
            4:  val = 32'h03FEAB76;
            5:  val = 32'h01FFD55B;
            6:  val = 32'h00FFFAAA;
            7:  val = 32'h007FFF55;
            8:  val = 32'h003FFFEA;
            9:  val = 32'h001FFFFD;
            10: val = 32'h000FFFFF;
            11: val = 32'h0007FFFF;
            12: val = 32'h0003FFFF;
            13: val = 32'h0001FFFF;
            14: val = 32'h0000FFFF;
            15: val = 32'h00007FFF;
            16: val = 32'h00003FFF;
            17: val = 32'h00001FFF;
            18: val = 32'h00000FFF;
            19: val = 32'h000007FF;
            20: val = 32'h000003FF;
            21: val = 32'h000001FF;
            22: val = 32'h000000FF;
            23: val = 32'h0000007F;
            24: val = 32'h0000003F;
            25: val = 32'h0000001F;
            26: val = 32'h0000000F;
            27: val = 32'h00000007;
            28: val = 32'h00000003;
            29: val = 32'h00000001;
            default: val = 32'h00000000;
        endcase
        return val;
    endfunction

endpackage

// ===== hdl/fovc_cordic_cell.sv =====
// one cordic micro-rotation cell with its own valid/ready stage register
// depends on fovc_pkg for the angle width and the arctangent table

module fovc_cordic_cell
    import fovc_pkg::*;
#(
    parameter int   IDX       = 0,
    parameter bit   VECTORING = 1'b0,
    parameter int   CW        = RW,
    parameter int   TW        = 17
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [CW-1:0] in_x,
    input  logic signed [CW-1:0] in_y,
    input  logic signed [ZW-1:0] in_z,
    input  logic        [TW-1:0] in_tag,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [CW-1:0] out_x,
    output logic signed [CW-1:0] out_y,
    output logic signed [ZW-1:0] out_z,
    output logic        [TW-1:0] out_tag
);

    logic                 valid_reg, valid_next;
    logic signed [CW-1:0] x_reg, x_next;
    logic signed [CW-1:0] y_reg, y_next;
    logic signed [ZW-1:0] z_reg, z_next;
    logic        [TW-1:0] tag_reg;
    logic signed [CW-1:0] dx, dy;
    logic signed [ZW-1:0] ang;
    logic                 ccw;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        dx  = in_x >>> IDX;
        dy  = in_y >>> IDX;
        ang = $signed({1'b0, fovc_atan(IDX)});
        // rotation follows the residual angle, vectoring drives y to zero
        if (VECTORING)
            ccw = (in_y <= 0);
        else
            ccw = (in_z >= 0);
        if (ccw)
        begin
            x_next = in_x - dy;
            y_next = in_y + dx;
            z_next = in_z - ang;
        end
        else
        begin
            x_next = in_x + dy;
            y_next = in_y - dx;
            z_next = in_z + ang;
        end
        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            z_reg   <= z_next;
            tag_reg <= in_tag;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_z     = z_reg;
    assign out_tag   = tag_reg;

endmodule

// ===== hdl/fovc_ratio_scale.sv =====
// clamps the rotated vector and scales one coordinate by the aspect ratio
// depends on fovc_pkg; sits between the rotation and the vectoring cell rows

module fovc_ratio_scale
    import fovc_pkg::*;
#(
    parameter int TW = 17
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic        [RATIO_W-1:0] ratio,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [RW-1:0]      in_x,
    input  logic signed [RW-1:0]      in_y,
    input  logic        [TW-1:0]      in_tag,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [VW-1:0]      out_x,
    output logic signed [VW-1:0]      out_y,
    output logic        [TW-1:0]      out_tag
);

    logic                 valid_reg, valid_next;
    logic signed [VW-1:0] x_reg, x_next;
    logic signed [VW-1:0] y_reg, y_next;
    logic        [TW-1:0] tag_reg;
    logic [CLAMP_W-1:0]   xc, yc, mul_in;
    logic [PROD_W-1:0]    prod;
    logic signed [VW-1:0] scaled;
    logic                 from_vertical;

    assign in_ready      = !valid_reg || out_ready;
    assign from_vertical = (in_tag[0] == OP_FROM_VERTICAL);

    always_comb
    begin
        xc     = in_x[RW-1] ? '0 : in_x[CLAMP_W-1:0];
        yc     = in_y[RW-1] ? '0 : in_y[CLAMP_W-1:0];
        mul_in = from_vertical ? yc : xc;
        prod   = PROD_W'(mul_in) * PROD_W'(ratio);
        scaled = $signed(VW'(prod[PROD_W-1:RATIO_FRAC]));
        if (from_vertical)
        begin
            x_next = $signed(VW'(xc));
            y_next = scaled;
        end
        else
        begin
            x_next = scaled;
            y_next = $signed(VW'(yc));
        end
        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            tag_reg <= in_tag;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_tag   = tag_reg;

endmodule

// ===== hdl/fov_axis_conversion_core.sv =====
// fov axis conversion core: horizontal <-> vertical field of view for a given aspect ratio
// depends on fovc_pkg, fovc_cordic_cell and fovc_ratio_scale
//
//  channel   signals                               content
//  s_axis    tvalid tready tdata tuser             given angle, tuser = 0 horizontal / 1 vertical
//  m_axis    tvalid tready tdata                   horizontal fov, vertical fov
//  cfg       cfg_valid cfg_ready cfg_data          aspect ratio, unsigned q8.8
//
// one request per cycle while the output is not stalled; registers in order: rotation row,
// ratio multiply, vectoring row, rounding register
// every stage has its own valid bit and ready term, so bubbles close up during a stall
// reset clears all valid bits and loads the aspect ratio with 1.0; cfg_ready is always high

module fov_axis_conversion_core
    import fovc_pkg::*;
#(
    parameter int ANGLE_BITS    = ANGLE_BITS_DEF,
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  logic [((ANGLE_BITS+7)/8)*8-1:0]        s_axis_tdata,  // fov_angle
    input  logic                                   s_axis_tuser,  // op
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    output logic [((2*ANGLE_BITS+7)/8)*8-1:0]      m_axis_tdata,  // horizontal_fov, vertical_fov
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [RATIO_W-1:0]                     cfg_data       // aspect_ratio
);

    localparam int N      = CORDIC_STAGES;
    localparam int TW     = ANGLE_BITS + 1;
    localparam int S      = FRAC_Q30 - (ANGLE_BITS - 2);
    localparam int OUT_W  = ((2*ANGLE_BITS+7)/8)*8;
    localparam int RSUM_W = ZW + 1;
    localparam logic [ANGLE_BITS-1:0] PI_Q  = ANGLE_BITS'(PI_Q60 >> (62 - ANGLE_BITS));
    localparam logic [RSUM_W-1:0]     RND   = RSUM_W'((64'd1 << S) >> 1);

    logic [RATIO_W-1:0] ratio_reg;

    // rotation row
    logic                 rv   [0:N];
    logic                 rr   [0:N];
    logic signed [RW-1:0] rx   [0:N];
    logic signed [RW-1:0] ry   [0:N];
    logic signed [ZW-1:0] rz   [0:N];
    logic [TW-1:0]        rtag [0:N];

    // vectoring row
    logic                 vv   [0:N];
    logic                 vr   [0:N];
    logic signed [VW-1:0] vx   [0:N];
    logic signed [VW-1:0] vy   [0:N];
    logic signed [ZW-1:0] vz   [0:N];
    logic [TW-1:0]        vtag [0:N];

    logic [ANGLE_BITS-1:0] fov_in, given;
    logic [ZW-1:0]         given_q30;

    logic                  m_valid_reg, m_valid_next;
    logic [ANGLE_BITS-1:0] horiz_reg, horiz_next;
    logic [ANGLE_BITS-1:0] vert_reg, vert_next;
    logic                  out_take;
    logic [ZW-2:0]         zc;
    logic [RSUM_W-1:0]     rsum, rsh;
    logic [ANGLE_BITS-1:0] rsat, tag_given;

    // config register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ratio_reg <= RATIO_RESET;
        else if (cfg_valid)
            ratio_reg <= cfg_data;
    end

    // input: saturate at pi, move to q30 and halve
    always_comb
    begin
        fov_in    = s_axis_tdata[ANGLE_BITS-1:0];
        given     = (fov_in > PI_Q) ? PI_Q : fov_in;
        given_q30 = ZW'(given) << S;
    end

    assign rv[0]         = s_axis_tvalid;
    assign s_axis_tready = rr[0];
    assign rx[0]         = RW'(64'd1 << FRAC_Q30);
    assign ry[0]         = '0;
    assign rz[0]         = $signed({1'b0, given_q30[ZW-1:1]});
    assign rtag[0]       = {given, s_axis_tuser};

    genvar i;
    generate
        for (i = 0; i < N; i++)
        begin : g_rot
            fovc_cordic_cell #(
                .IDX       (i),
                .VECTORING (1'b0),
                .CW        (RW),
                .TW        (TW)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (rv[i]),
                .in_ready  (rr[i]),
                .in_x      (rx[i]),
                .in_y      (ry[i]),
                .in_z      (rz[i]),
                .in_tag    (rtag[i]),
                .out_valid (rv[i+1]),
                .out_ready (rr[i+1]),
                .out_x     (rx[i+1]),
                .out_y     (ry[i+1]),
                .out_z     (rz[i+1]),
                .out_tag   (rtag[i+1])
            );
        end
    endgenerate

    fovc_ratio_scale #(
        .TW        (TW)
    ) u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .ratio     (ratio_reg),
        .in_valid  (rv[N]),
        .in_ready  (rr[N]),
        .in_x      (rx[N]),
        .in_y      (ry[N]),
        .in_tag    (rtag[N]),
        .out_valid (vv[0]),
        .out_ready (vr[0]),
        .out_x     (vx[0]),
        .out_y     (vy[0]),
        .out_tag   (vtag[0])
    );

    assign vz[0] = '0;

    generate
        for (i = 0; i < N; i++)
        begin : g_vec
            fovc_cordic_cell #(
                .IDX       (i),
                .VECTORING (1'b1),
                .CW        (VW),
                .TW        (TW)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (vv[i]),
                .in_ready  (vr[i]),
                .in_x      (vx[i]),
                .in_y      (vy[i]),
                .in_z      (vz[i]),
                .in_tag    (vtag[i]),
                .out_valid (vv[i+1]),
                .out_ready (vr[i+1]),
                .out_x     (vx[i+1]),
                .out_y     (vy[i+1]),
                .out_z     (vz[i+1]),
                .out_tag   (vtag[i+1])
            );
        end
    endgenerate

    // output: double, round to nearest, saturate at pi
    assign out_take = !m_valid_reg || m_axis_tready;
    assign vr[N]    = out_take;

    always_comb
    begin
        zc        = vz[N][ZW-1] ? '0 : vz[N][ZW-2:0];
        rsum      = RSUM_W'({zc, 1'b0}) + RND;
        rsh       = rsum >> S;
        rsat      = (rsh > RSUM_W'(PI_Q)) ? PI_Q : rsh[ANGLE_BITS-1:0];
        tag_given = vtag[N][TW-1:1];
        if (vtag[N][0] == OP_FROM_VERTICAL)
        begin
            horiz_next = rsat;
            vert_next  = tag_given;
        end
        else
        begin
            horiz_next = tag_given;
            vert_next  = rsat;
        end
        m_valid_next = out_take ? vv[N] : m_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else
            m_valid_reg <= m_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (out_take)
        begin
            horiz_reg <= horiz_next;
            vert_reg  <= vert_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = OUT_W'({vert_reg, horiz_reg});

    // checks
    a_horiz_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (horiz_reg <= PI_Q))
        else $error("horizontal fov above pi");

    a_vert_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (vert_reg <= PI_Q))
        else $error("vertical fov above pi");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without a blocked result");

    a_reset_empty: assert property (@(posedge clk)
        !rst_n |-> !m_axis_tvalid)
        else $error("result valid during reset");

endmodule
